// ===== hdl/rotating_server_assigner_defines.svh =====
// Assertion macros shared by the rotating server assigner.
// Expects signals named clk and arst_n in the including module.
`ifndef ROTATING_SERVER_ASSIGNER_DEFINES_SVH
`define ROTATING_SERVER_ASSIGNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rsa_pkg.sv =====
// Shared constants, types and result codes of the rotating server assigner.
// No dependencies; used by rsa_pick and rotating_server_assigner.
package rsa_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int SRV_W       = $clog2(MAX_SERVERS);
	localparam int CNT_W       = SRV_W + 1;
	localparam int CFG_W       = 5;
	localparam int TIME_W      = 31;
	localparam int FIN_W       = 33;
	localparam int LOAD_W      = 48;
	localparam int KIND_W      = 2;
	localparam int ID_W        = 4;

	localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	typedef struct packed {
		logic             found;
		logic [SRV_W-1:0] id;
	} pick_t;

endpackage

// ===== hdl/rsa_pick.sv =====
// Rotating priority pick among free servers in use.
// Depends on rsa_pkg for widths and the pick_t result type.
module rsa_pick (
	input  logic [rsa_pkg::MAX_SERVERS-1:0] free,
	input  logic [rsa_pkg::SRV_W-1:0]       pref,
	input  logic [rsa_pkg::CNT_W-1:0]       n_eff,
	output rsa_pkg::pick_t                  pick
);
	import rsa_pkg::*;

	logic [MAX_SERVERS-1:0] in_use;
	logic [MAX_SERVERS-1:0] upper;
	logic                   hi_found;
	logic                   lo_found;
	logic [SRV_W-1:0]       hi_id;
	logic [SRV_W-1:0]       lo_id;

	always_comb begin
		for (int i = 0; i < MAX_SERVERS; i++) begin
			in_use[i] = free[i] && (CNT_W'(i) < n_eff);
			upper[i]  = in_use[i] && (SRV_W'(i) >= pref);
		end
	end

	// Lowest set bit of each mask; the upper half wins when it has one.
	always_comb begin
		hi_found = 1'b0;
		lo_found = 1'b0;
		hi_id    = '0;
		lo_id    = '0;
		for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
			if (upper[i]) begin
				hi_found = 1'b1;
				hi_id    = SRV_W'(i);
			end
			if (in_use[i]) begin
				lo_found = 1'b1;
				lo_id    = SRV_W'(i);
			end
		end
		pick.found = hi_found || lo_found;
		pick.id    = hi_found ? hi_id : lo_id;
	end

endmodule

// ===== hdl/rotating_server_assigner.sv =====
// Top level of the rotating server assigner: sequencer, server state and output register.
// Depends on rsa_pkg, rsa_pick and rotating_server_assigner_defines.svh.
//
// Usage. Items enter on the s_axis channel: tuser carries the operation (assign or
// report) and tdata carries the start time and duration of a request. Results leave
// on the m_axis channel: tuser is the result kind, tdata the server id and load, and
// tlast marks the final result of an input item. The user must see that the server count
// is written through cfg_we/cfg_wdata only while the block is idle; nothing enforces it.
// Timing. A request is accepted in the idle state, releases finished servers and picks a
// free one with the rotating priority encoder in the release state, and passes through
// the shared saturating adder in the add state, which loads the result register. After
// the server count has been lowered, the release state first reduces the rotating pointer
// below it. A report walks the servers twice through the shared comparator, once to find
// the maximum and once to emit. The block takes one item at a time.
// Reset clears every busy flag, finish time and load, the pointer, and sets the server
// count to sixteen. When the receiver stalls, the result waits in the output register
// and the sequencer holds until that register frees up; nothing is dropped.
`include "rotating_server_assigner_defines.svh"

module rotating_server_assigner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,      // num_servers
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [30:0] start_time, [61:31] duration, zero fill
	input  logic        s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [3:0] server_id, [51:4] server_load, zero fill
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last
);
	import rsa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_MAX  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]              state_q;
	logic [CFG_W-1:0]        num_servers_q;
	logic [SRV_W-1:0]        req_q;
	logic [SRV_W-1:0]        idx_q;
	logic                    found_q;
	logic [TIME_W-1:0]       start_q;
	logic [TIME_W-1:0]       dur_q;
	logic [LOAD_W-1:0]       max_q;
	logic [SRV_W-1:0]        last_q;
	logic [MAX_SERVERS-1:0]  busy_q;
	logic [FIN_W-1:0]        finish_q [MAX_SERVERS];
	logic [LOAD_W-1:0]       acc_q    [MAX_SERVERS];

	logic                    out_valid_q;
	logic [KIND_W-1:0]       out_kind_q;
	logic [ID_W-1:0]         out_id_q;
	logic [LOAD_W-1:0]       out_load_q;
	logic                    out_last_q;

	logic [CNT_W-1:0]        n_eff;
	logic                    out_free;
	logic                    in_acc;
	logic [MAX_SERVERS-1:0]  release_mask;
	logic [MAX_SERVERS-1:0]  free_mask;
	pick_t                   pick;
	logic                    pref_wrap;
	logic [SRV_W-1:0]        req_next;
	logic                    idx_end;
	logic [LOAD_W-1:0]       acc_rd;
	logic [LOAD_W:0]         sum;
	logic [LOAD_W-1:0]       sat_sum;

	// Effective server count: zero acts as one, anything above the built count is clamped.
	always_comb begin
		if (num_servers_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (num_servers_q > CFG_W'(MAX_SERVERS)) begin
			n_eff = CNT_W'(MAX_SERVERS);
		end else begin
			n_eff = CNT_W'(num_servers_q);
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Release check covers every built server, in use or not.
	always_comb begin
		for (int i = 0; i < MAX_SERVERS; i++) begin
			release_mask[i] = busy_q[i] && (finish_q[i] <= FIN_W'(start_q));
			free_mask[i]    = !(busy_q[i] && !release_mask[i]);
		end
	end

	rsa_pick u_pick (
		.free  (free_mask),
		.pref  (req_q),
		.n_eff (n_eff),
		.pick  (pick)
	);

	// The pointer is brought below the server count in ST_REL before it is used here.
	assign pref_wrap = (CNT_W'(req_q) + CNT_W'(1)) == n_eff;
	assign req_next  = pref_wrap ? '0 : SRV_W'(req_q + SRV_W'(1));
	assign idx_end   = (CNT_W'(idx_q) == CNT_W'(n_eff - CNT_W'(1)));

	// The one shared datapath: a single load read, a saturating adder and a comparator.
	assign acc_rd  = acc_q[idx_q];
	assign sum     = {1'b0, acc_rd} + (LOAD_W + 1)'(dur_q);
	assign sat_sum = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q <= CFG_W'(MAX_SERVERS);
		end else if (cfg_we) begin
			num_servers_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= '0;
			busy_q  <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				finish_q[i] <= '0;
				acc_q[i]    <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (s_axis_tuser == OP_REPORT) ? ST_MAX : ST_REL;
					end
				end
				ST_REL: begin
					if (CNT_W'(req_q) >= n_eff) begin
						// Count was lowered: reduce the pointer one subtraction per cycle.
						req_q <= SRV_W'(req_q - SRV_W'(n_eff));
					end else begin
						busy_q  <= busy_q & ~release_mask;
						req_q   <= req_next;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (out_free) begin
						if (found_q) begin
							acc_q[idx_q]    <= sat_sum;
							busy_q[idx_q]   <= 1'b1;
							finish_q[idx_q] <= FIN_W'(start_q) + FIN_W'(dur_q);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MAX: begin
					if (idx_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (acc_rd == max_q && out_free && idx_q == last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the sequencer; their values only matter inside a sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					start_q <= s_axis_tdata[TIME_W-1:0];
					dur_q   <= s_axis_tdata[2*TIME_W-1:TIME_W];
					idx_q   <= '0;
					max_q   <= '0;
					last_q  <= '0;
				end
			end
			ST_REL: begin
				idx_q   <= pick.id;
				found_q <= pick.found;
			end
			ST_MAX: begin
				if (acc_rd > max_q) begin
					max_q <= acc_rd;
				end
				if (acc_rd >= max_q) begin
					last_q <= idx_q;
				end
				idx_q <= idx_end ? '0 : SRV_W'(idx_q + SRV_W'(1));
			end
			ST_EMIT: begin
				if (acc_rd != max_q || out_free) begin
					idx_q <= SRV_W'(idx_q + SRV_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_ADD) || (state_q == ST_EMIT && acc_rd == max_q);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_ADD) begin
				out_kind_q <= found_q ? KIND_ASSIGN : KIND_DROP;
				out_id_q   <= found_q ? ID_W'(idx_q) : '0;
				out_load_q <= found_q ? sat_sum : '0;
				out_last_q <= 1'b1;
			end else if (state_q == ST_EMIT && acc_rd == max_q) begin
				out_kind_q <= KIND_REPORT;
				out_id_q   <= ID_W'(idx_q);
				out_load_q <= max_q;
				out_last_q <= (idx_q == last_q);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, out_load_q, out_id_q};

	// A dropped request reports neither a server nor a load.
	`RSA_ASSERT_IMP(a_drop_zero, m_axis_tvalid && m_axis_tuser == KIND_DROP,
		m_axis_tdata == '0 && m_axis_tlast, "dropped result carries payload")
	// An assignment leaves its server marked busy.
	`RSA_ASSERT_NXT(a_assign_busy, state_q == ST_ADD && found_q && out_free,
		busy_q[$past(idx_q)], "assigned server not busy")
	// The pointer lies below the server count once the pick is made.
	`RSA_ASSERT_IMP(a_ptr_range, state_q == ST_ADD, CNT_W'(req_q) < n_eff,
		"rotating pointer out of range")
	// An accepted item keeps the input closed in the next cycle.
	`RSA_ASSERT_NXT(a_one_item, in_acc, !s_axis_tready, "second item taken while busy")

endmodule
